// ----- sv/abkf_pkg.sv -----
// Package for the angle and gyro bias Kalman filter.
// Holds fixed-point widths, register indexes, reset values and saturation helper.
// No dependencies.
package abkf_pkg;

	localparam int DataW  = 32;
	localparam int RegW   = 30;
	localparam int IdxW   = 2;
	localparam int QShift = 30;

	localparam logic [IdxW-1:0] RegAngleNoise   = 2'd0;
	localparam logic [IdxW-1:0] RegBiasNoise    = 2'd1;
	localparam logic [IdxW-1:0] RegMeasureNoise = 2'd2;
	localparam logic [IdxW-1:0] RegStepTime     = 2'd3;

	localparam logic [RegW-1:0] AngleNoiseRst   = 30'd1073742;
	localparam logic [RegW-1:0] BiasNoiseRst    = 30'd536871;
	localparam logic [RegW-1:0] MeasureNoiseRst = 30'd53687091;
	localparam logic [RegW-1:0] StepTimeRst     = 30'd3221225;
	localparam logic signed [DataW-1:0] OneQ30  = 32'sh4000_0000;

	typedef logic signed [DataW-1:0] word_t;

	// clamp a wide signed value to the signed 32-bit range
	function automatic word_t sat32(input logic signed [67:0] v);
		if (v > 68'sh0_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -68'sh0_8000_0000)
			return 32'sh8000_0000;
		else
			return v[DataW-1:0];
	endfunction

endpackage

// ----- sv/abkf_if.sv -----
// Valid/ready stream interfaces for the input samples and the results.
// Depends on abkf_pkg.
interface abkf_in_if;
	import abkf_pkg::*;
	logic  valid;
	logic  ready;
	word_t measured_rate;
	word_t measured_angle;
	modport source (output valid, output measured_rate, output measured_angle, input ready);
	modport sink (input valid, input measured_rate, input measured_angle, output ready);
endinterface

interface abkf_out_if;
	import abkf_pkg::*;
	logic  valid;
	logic  ready;
	word_t angle_estimate;
	word_t rate_estimate;
	word_t bias_estimate;
	modport source (output valid, output angle_estimate, output rate_estimate,
		output bias_estimate, input ready);
	modport sink (input valid, input angle_estimate, input rate_estimate,
		input bias_estimate, output ready);
endinterface

// ----- sv/angle_bias_kalman_filter.sv -----
// Top level of the angle and gyro bias Kalman filter: sequencer, state and registers.
// Depends on abkf_pkg, abkf_if, abkf_mac and abkf_div.
//
// Use: samples (measured_rate, measured_angle, Q16.16) come in on in_ch and
// one result (angle, rate, bias estimates, Q16.16) per sample leaves on out_ch.
// Configuration registers (noises, step time, unsigned Q0.30) must be written
// through cfg_we / cfg_idx / cfg_data only while the block is idle; the block
// itself does not enforce this. Each sample passes through the idle state that
// takes it, eleven uses of the shared multiplier, two divider passes (launch,
// 64 quotient bits, completion) and the output step, which waits while a
// result is pending. When measure noise plus the predicted paa is zero the
// divider is skipped and the gains are zero. in_ch.ready is high only in the
// idle state.
// The result sits in an output register; the next sample is taken while
// it waits, and a new result is only written once the old one is taken.
// Reset returns the state to zero angle and bias, unit diagonal covariance
// and the default register values; no result is pending after reset.
module angle_bias_kalman_filter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [abkf_pkg::IdxW-1:0]  cfg_idx,
	input  logic [abkf_pkg::RegW-1:0]  cfg_data,
	abkf_in_if.sink                    in_ch,
	abkf_out_if.source                 out_ch
);
	import abkf_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0,  S_PRED = 5'd1,  S_PAA = 5'd2,  S_PAB = 5'd3,
		S_PBA = 5'd4, S_PBB = 5'd5, S_DIV0 = 5'd6, S_DIV1 = 5'd7, S_ANG = 5'd8,
		S_BIAS = 5'd9, S_CAA = 5'd10, S_CAB = 5'd11, S_CBA = 5'd12, S_CBB = 5'd13,
		S_OUT = 5'd14;

	logic [RegW-1:0] angle_noise_q, bias_noise_q, measure_noise_q, step_time_q;
	word_t angle_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
	word_t rate_q, meas_q, pred_q, paa_q, pab_q, pba_q, pbb_q, k0_q, k1_q;
	logic [4:0] state_q;
	logic       phase_q, div_go_q;
	logic signed [33:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [33:0] mul_base;
	logic               mul_sub;
	word_t              mul_res;
	logic signed [63:0] den, div_num, div_quot;
	logic               div_done;
	logic signed [32:0] err;
	logic               out_valid_q;
	word_t              oang_q, orate_q, obias_q;

	assign den     = 64'(signed'({1'b0, measure_noise_q})) + 64'(paa_q);
	assign div_num = (state_q == S_DIV0 ? 64'(paa_q) : 64'(pba_q)) <<< QShift;
	assign err     = 33'(meas_q) - 33'(pred_q);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0; mul_b = 33'(signed'({1'b0, step_time_q})); mul_base = '0; mul_sub = 1'b0;
		unique case (state_q)
			S_PRED: begin mul_a = 34'(rate_q) - 34'(bias_q); mul_base = 34'(angle_q); end
			S_PAA: begin
				mul_a = 34'(signed'({1'b0, angle_noise_q})) - 34'(cab_q) - 34'(cba_q);
				mul_base = 34'(caa_q);
			end
			S_PAB: begin mul_a = -34'(cbb_q); mul_base = 34'(cab_q); end
			S_PBA: begin mul_a = -34'(cbb_q); mul_base = 34'(cba_q); end
			S_PBB: begin mul_a = 34'(signed'({1'b0, bias_noise_q})); mul_base = 34'(cbb_q); end
			S_ANG: begin mul_a = 34'(k0_q); mul_b = err; mul_base = 34'(pred_q); end
			S_BIAS: begin mul_a = 34'(k1_q); mul_b = err; mul_base = 34'(bias_q); end
			S_CAA: begin
				mul_a = 34'(k0_q); mul_b = 33'(paa_q); mul_base = 34'(paa_q); mul_sub = 1'b1;
			end
			S_CAB: begin
				mul_a = 34'(k0_q); mul_b = 33'(pab_q); mul_base = 34'(pab_q); mul_sub = 1'b1;
			end
			S_CBA: begin
				mul_a = 34'(k1_q); mul_b = 33'(paa_q); mul_base = 34'(pba_q); mul_sub = 1'b1;
			end
			S_CBB: begin
				mul_a = 34'(k1_q); mul_b = 33'(pab_q); mul_base = 34'(pbb_q); mul_sub = 1'b1;
			end
			default: ;
		endcase
	end

	abkf_mac u_mac (
		.clk(clk), .a(mul_a), .b(mul_b), .base(mul_base), .sub(mul_sub), .res(mul_res)
	);

	abkf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(div_num), .den(den),
		.done(div_done), .quot(div_quot)
	);

	assign in_ch.ready = (state_q == S_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_noise_q   <= AngleNoiseRst;
			bias_noise_q    <= BiasNoiseRst;
			measure_noise_q <= MeasureNoiseRst;
			step_time_q     <= StepTimeRst;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegAngleNoise:   angle_noise_q   <= cfg_data;
				RegBiasNoise:    bias_noise_q    <= cfg_data;
				RegMeasureNoise: measure_noise_q <= cfg_data;
				RegStepTime:     step_time_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: a multiply step issues operands, then takes the registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			angle_q <= '0; bias_q <= '0; cab_q <= '0; cba_q <= '0;
			caa_q <= OneQ30; cbb_q <= OneQ30;
		end else begin
			div_go_q <= 1'b0;
			// output register reload is handled in the output step
			if (out_valid_q && out_ch.ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						rate_q  <= in_ch.measured_rate;
						meas_q  <= in_ch.measured_angle;
						state_q <= S_PRED;
						phase_q <= 1'b0;
					end
				end
				S_DIV0, S_DIV1: begin
					if (!phase_q) begin
						if (den == 64'sd0) begin
							k0_q <= '0; k1_q <= '0; state_q <= S_ANG;
						end else begin
							div_go_q <= 1'b1; phase_q <= 1'b1;
						end
					end else if (div_done) begin
						phase_q <= 1'b0;
						if (state_q == S_DIV0) begin
							k0_q <= sat32(68'(div_quot)); state_q <= S_DIV1;
						end else begin
							k1_q <= sat32(68'(div_quot)); state_q <= S_ANG;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						oang_q  <= angle_q;
						obias_q <= bias_q;
						orate_q <= sat32(68'(rate_q) - 68'(bias_q));
						state_q <= S_IDLE;
					end
				end
				default: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						state_q <= state_q + 5'd1;
						case (state_q)
							S_PRED: pred_q <= mul_res;
							S_PAA:  paa_q  <= mul_res;
							S_PAB:  pab_q  <= mul_res;
							S_PBA:  pba_q  <= mul_res;
							S_PBB:  pbb_q  <= mul_res;
							S_ANG:  angle_q <= mul_res;
							S_BIAS: bias_q <= mul_res;
							S_CAA:  caa_q  <= mul_res;
							S_CAB:  cab_q  <= mul_res;
							S_CBA:  cba_q  <= mul_res;
							S_CBB:  cbb_q  <= mul_res;
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.angle_estimate = oang_q;
	assign out_ch.rate_estimate  = orate_q;
	assign out_ch.bias_estimate  = obias_q;

	// a sample is only taken in the idle state
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> state_q == S_PRED)
		else $error("sample taken outside idle");
	// a pending result is never overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(oang_q))
		else $error("pending result lost");
	// divider is started only from a gain step
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> state_q == S_DIV0 || state_q == S_DIV1)
		else $error("divider started out of sequence");
endmodule

// ----- sv/abkf_div.sv -----
// Restoring serial divider: signed 64-bit numerator by signed 64-bit denominator.
// One quotient bit per cycle, truncation toward zero. Depends on abkf_pkg.
module abkf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output logic               done,
	output logic signed [63:0] quot
);
	import abkf_pkg::*;

	logic [63:0] num_mag, den_mag;
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [64:0] trial;

	assign num_mag = num[63] ? 64'(-num) : num;
	assign den_mag = den[63] ? 64'(-den) : den;
	assign trial   = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	// shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			dvs_q <= den_mag;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ----- sv/abkf_mac.sv -----
// Shared multiply unit: a*b registered, then floor shift by 30 and add/sub with saturation.
// Depends on abkf_pkg.
module abkf_mac (
	input  logic                     clk,
	input  logic signed [33:0]       a,
	input  logic signed [32:0]       b,
	input  logic signed [33:0]       base,
	input  logic                     sub,
	output abkf_pkg::word_t          res
);
	import abkf_pkg::*;

	logic signed [66:0] prod_s1;
	logic signed [33:0] base_s1;
	logic               sub_s1;
	logic signed [67:0] sh, sum;

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		base_s1 <= base;
		sub_s1  <= sub;
	end

	// arithmetic shift floors toward minus infinity
	assign sh  = 68'(prod_s1 >>> QShift);
	assign sum = sub_s1 ? 68'(base_s1) - sh : 68'(base_s1) + sh;
	assign res = sat32(sum);
endmodule

// ----- verif/angle_bias_kalman_filter_tb.sv -----
// Self-checking testbench for the angle and gyro bias Kalman filter.
// Drives abkf_in_if samples; checks each result against a bit-exact model or table row.
// Depends on abkf_pkg, abkf_if and angle_bias_kalman_filter.
`timescale 1ns / 100ps

module angle_bias_kalman_filter_tb;
	import abkf_pkg::*;

	typedef struct packed {
		word_t angle;
		word_t rate;
		word_t bias;
	} estimate_t;

	// directed row: sample, and a typed-in expectation where one is given
	typedef struct {
		word_t     rate;
		word_t     angle;
		logic      fixed;
		estimate_t want;
	} sample_row_t;

	localparam int WatchdogLimit = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IdxW-1:0] cfg_idx;
	logic [RegW-1:0] cfg_data;

	abkf_in_if  in_ch ();
	abkf_out_if out_ch ();

	angle_bias_kalman_filter u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// filter model state and registers
	logic [RegW-1:0] m_qa, m_qb, m_r, m_dt;
	word_t m_ang, m_bias, m_paa, m_pab, m_pba, m_pbb;

	estimate_t estimates_q[$];
	int mismatches;
	int idle_cycles;
	logic timed_out;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic signed [67:0] fl30(input logic signed [67:0] v);
		return v >>> QShift;
	endfunction

	function automatic word_t gain_calc(input word_t num, input logic signed [67:0] den);
		logic signed [67:0] n;
		if (den == 0)
			return '0;
		n = 68'(num) <<< QShift;
		return sat32(n / den);
	endfunction

	task automatic model_reset();
		m_qa = AngleNoiseRst; m_qb = BiasNoiseRst; m_r = MeasureNoiseRst; m_dt = StepTimeRst;
		m_ang = '0; m_bias = '0; m_paa = OneQ30; m_pab = '0; m_pba = '0; m_pbb = OneQ30;
	endtask

	function automatic estimate_t filter_update(input word_t rate, input word_t meas);
		logic signed [67:0] dt, daa, dab, den, err;
		word_t pred, paa, pab, pba, pbb, k0, k1;
		estimate_t e;
		dt = 68'($signed({1'b0, m_dt}));
		pred = sat32(68'(m_ang) + fl30((68'(rate) - 68'(m_bias)) * dt));
		daa = 68'($signed({1'b0, m_qa})) - 68'(m_pab) - 68'(m_pba);
		dab = -68'(m_pbb);
		paa = sat32(68'(m_paa) + fl30(daa * dt));
		pab = sat32(68'(m_pab) + fl30(dab * dt));
		pba = sat32(68'(m_pba) + fl30(dab * dt));
		pbb = sat32(68'(m_pbb) + fl30(68'($signed({1'b0, m_qb})) * dt));
		den = 68'($signed({1'b0, m_r})) + 68'(paa);
		k0 = gain_calc(paa, den);
		k1 = gain_calc(pba, den);
		err = 68'(meas) - 68'(pred);
		m_ang = sat32(68'(pred) + fl30(68'(k0) * err));
		m_bias = sat32(68'(m_bias) + fl30(68'(k1) * err));
		m_paa = sat32(68'(paa) - fl30(68'(k0) * 68'(paa)));
		m_pab = sat32(68'(pab) - fl30(68'(k0) * 68'(pab)));
		m_pba = sat32(68'(pba) - fl30(68'(k1) * 68'(paa)));
		m_pbb = sat32(68'(pbb) - fl30(68'(k1) * 68'(pab)));
		e.angle = m_ang;
		e.rate = sat32(68'(rate) - 68'(m_bias));
		e.bias = m_bias;
		return e;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(150, 20);
	endfunction

	// register write, only while idle
	task automatic reg_write(input logic [IdxW-1:0] idx, input logic [RegW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1; cfg_idx = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			RegAngleNoise:   m_qa = val;
			RegBiasNoise:    m_qb = val;
			RegMeasureNoise: m_r = val;
			default:         m_dt = val;
		endcase
	endtask

	task automatic drain();
		while (estimates_q.size() != 0 && !timed_out)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	// one sample transfer; returns once accepted
	task automatic send_sample(input word_t rate, input word_t meas, input logic fixed,
			input estimate_t want);
		estimate_t e;
		repeat (gap_len()) @(negedge clk);
		in_ch.valid = 1'b1; in_ch.measured_rate = rate; in_ch.measured_angle = meas;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		e = filter_update(rate, meas);
		if (fixed && e != want)
			$display("model disagrees with table row: %h vs %h", e, want);
		estimates_q.push_back(fixed ? want : e);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return word_t'($urandom);
			default: return word_t'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	function automatic logic [RegW-1:0] rand_reg(input logic nonzero);
		case ($urandom_range(3))
			0: return nonzero ? 30'd1 : 30'd0;
			1: return 30'h3FFF_FFFF;
			2: return RegW'($urandom);
			default: return RegW'($urandom_range(60000000, 1));
		endcase
	endfunction

	// result sink: stalls of random length, zero included, each followed by ready
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = 1'b0;
			repeat (gap_len()) @(negedge clk);
			out_ch.ready = 1'b1;
		end
	end

	// compare each result transfer against the oldest expectation
	always @(posedge clk) begin
		estimate_t got, exp;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.angle_estimate, out_ch.rate_estimate, out_ch.bias_estimate};
			if (estimates_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result with nothing expected: %h", got);
			end else begin
				exp = estimates_q.pop_front();
				if (got != exp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: angle %h/%h rate %h/%h bias %h/%h (exp/got)",
							exp.angle, got.angle, exp.rate, got.rate, exp.bias, got.bias);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		sample_row_t rows[$];
		estimate_t none;
		int n;
		none = '0;
		timed_out = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_idx = RegAngleNoise; cfg_data = '0;
		in_ch.valid = 1'b0; in_ch.measured_rate = '0; in_ch.measured_angle = '0;
		model_reset();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (5) @(negedge clk);

		// directed table: first row after reset with zero inputs gives all zero
		rows.push_back('{'0, '0, 1'b1, none});
		rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, none});
		rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 1'b0, none});
		rows.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, none});
		rows.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, none});
		rows.push_back('{32'sh0001_0000, 32'sh0000_8000, 1'b0, none});
		rows.push_back('{-32'sh0001_0000, 32'shFFFF_FFFF, 1'b0, none});
		rows.push_back('{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, none});
		foreach (rows[i]) send_sample(rows[i].rate, rows[i].angle, rows[i].fixed, rows[i].want);
		drain();

		// extremes of each register, zero measurement noise included
		reg_write(RegStepTime, 30'h3FFF_FFFF);
		reg_write(RegAngleNoise, 30'h3FFF_FFFF);
		reg_write(RegBiasNoise, 30'h3FFF_FFFF);
		reg_write(RegMeasureNoise, 30'd1);
		for (int i = 0; i < 6; i++) send_sample(rand_word(), rand_word(), 1'b0, none);
		drain();
		reg_write(RegMeasureNoise, 30'd0);
		reg_write(RegAngleNoise, 30'd0);
		reg_write(RegBiasNoise, 30'd0);
		reg_write(RegStepTime, 30'd1);
		for (int i = 0; i < 6; i++) send_sample(rand_word(), rand_word(), 1'b0, none);
		drain();

		// random phases with fresh register settings
		n = 0;
		while (n < 1130) begin
			reg_write(RegAngleNoise, rand_reg(1'b0));
			reg_write(RegBiasNoise, rand_reg(1'b0));
			reg_write(RegMeasureNoise, ($urandom_range(15) == 0) ? 30'd0 : rand_reg(1'b1));
			reg_write(RegStepTime, rand_reg(1'b1));
			for (int i = 0; i < 60; i++) begin
				send_sample(rand_word(), rand_word(), 1'b0, none);
				n++;
			end
			drain();
		end

		if (mismatches == 0 && estimates_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/abkf_pkg.sv
sv/abkf_if.sv
sv/abkf_div.sv
sv/abkf_mac.sv
sv/angle_bias_kalman_filter.sv
verif/angle_bias_kalman_filter_tb.sv
